// ===== design/stpe_pkg.sv =====
// ----------------------------------------------------------------------------
// stpe_pkg: shared definitions for the sine table / polynomial evaluator
// Fixed-point constants, pipeline stage map, side-band types and the
// elaboration-time builders for the sine/cosine table and the Taylor
// coefficients.
// ----------------------------------------------------------------------------
package stpe_pkg;

   // Table points per octant and polynomial length
   localparam int TABLE_BITS   = 3;
   localparam int POLY_TERMS   = 6;
   localparam int TABLE_SIZE   = 1 << TABLE_BITS;
   localparam int SERIES_TERMS = 14;

   // Width of the coarse step index and of its reciprocal estimate
   localparam int N_W     = TABLE_BITS + 8;
   localparam int RECIP_W = TABLE_BITS + 9;

   // Fixed-point constants (Q.60 unless noted)
   localparam logic [63:0]        PI_Q60    = 64'h3243_F6A8_885A_308D;
   localparam logic signed [63:0] ONE_Q60   = 64'sh1000_0000_0000_0000;
   localparam logic [63:0]        ROUND_Q60 = 64'h0800_0000_0000_0000;
   localparam logic [63:0]        STEP56    = PI_Q60 >> (6 + TABLE_BITS);
   localparam logic [63:0]        STEP60    = PI_Q60 >> (2 + TABLE_BITS);
   localparam logic [127:0]       RECIP_WIDE = (128'd1 << 64) / {64'd0, STEP56};
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_WIDE[RECIP_W-1:0];

   // Pipeline stage map
   localparam int RANGE_STAGES   = 6;
   localparam int MUL_STAGES     = 3;
   localparam int HORNER_BASE    = RANGE_STAGES;
   localparam int HORNER_STAGES  = MUL_STAGES * (POLY_TERMS - 1);
   localparam int FINAL_BASE     = HORNER_BASE + HORNER_STAGES;
   localparam int ADD_STAGE      = FINAL_BASE + MUL_STAGES;
   localparam int ABS_STAGE      = ADD_STAGE + 1;
   localparam int ROUND_STAGE    = ABS_STAGE + 1;
   localparam int OUT_STAGE      = ROUND_STAGE + 1;
   localparam int PIPE_STAGES    = OUT_STAGE + 1;
   localparam int SB_LEN         = HORNER_STAGES + MUL_STAGES;

   typedef logic [TABLE_SIZE-1:0][63:0] tab_type;

   // Per-item control that rides along the polynomial stages
   typedef struct packed {
      logic [TABLE_BITS-1:0] idx;
      logic                  is_cos;
      logic                  negative;
   } side_type;

   // Signed-magnitude Q.60 product, rounded half up on the magnitude
   function automatic logic signed [63:0] mul60_f(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      logic [63:0]  r;
      logic         neg;
      neg = a[63] ^ b[63];
      ua  = a[63] ? (64'd0 - a) : a;
      ub  = b[63] ? (64'd0 - b) : b;
      p   = ({64'd0, ua} * {64'd0, ub}) + {64'd0, ROUND_Q60};
      r   = {1'b0, p[122:60]};
      return neg ? (64'd0 - r) : r;
   endfunction

   // Unsigned quotient by shift and subtract; the builders only divide
   // non-negative values
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sine or cosine of each table angle, by a truncated Taylor series
   function automatic tab_type build_tab(input logic cos_sel);
      tab_type                tab;
      logic signed [63:0]     a;
      logic signed [63:0]     a2;
      logic signed [63:0]     st;
      logic signed [63:0]     ct;
      logic signed [63:0]     s;
      logic signed [63:0]     c;
      logic signed [63:0]     dv_s;
      logic signed [63:0]     dv_c;
      int                     i;
      int                     k;
      tab = '0;
      for (i = 0; i < TABLE_SIZE; i++) begin
         a  = 64'(STEP60 * 64'(i));
         a2 = mul60_f(a, a);
         st = a;
         ct = ONE_Q60;
         s  = a;
         c  = ONE_Q60;
         for (k = 1; k <= SERIES_TERMS; k++) begin
            dv_s = 64'((2 * k) * (2 * k + 1));
            dv_c = 64'((2 * k - 1) * (2 * k));
            st   = signed'(udiv64(mul60_f(st, a2), dv_s));
            ct   = signed'(udiv64(mul60_f(ct, a2), dv_c));
            if ((k & 1) == 1) begin
               s = s - st;
               c = c - ct;
            end else begin
               s = s + st;
               c = c + ct;
            end
         end
         tab[i] = cos_sel ? c : s;
      end
      return tab;
   endfunction

   // Taylor coefficient k of sin (cos_lane = 0) or cos (cos_lane = 1)
   function automatic logic signed [63:0] poly_coef(input logic cos_lane, input int k);
      logic signed [63:0] fact;
      logic signed [63:0] c;
      int                 m;
      fact = 64'sd1;
      for (m = 2; m <= k; m++) begin
         fact = fact * 64'(m);
      end
      c = signed'(udiv64(ONE_Q60, fact));
      if (((k >> 1) & 1) == 1) begin
         c = 64'sd0 - c;
      end
      if ((k & 1) == 1) begin
         return cos_lane ? 64'sd0 : c;
      end
      return cos_lane ? c : 64'sd0;
   endfunction

   localparam tab_type SIN_TAB = build_tab(1'b0);
   localparam tab_type COS_TAB = build_tab(1'b1);

endpackage

// ===== design/stpe_ctl.sv =====
// ----------------------------------------------------------------------------
// stpe_ctl: pipeline valid tracking
// Holds one valid bit per stage and computes per-stage load enables so that
// bubbles close up while the result side is stalled.
// ----------------------------------------------------------------------------
module stpe_ctl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               rsp_stall,
   output logic                               req_stall,
   output logic                               rsp_valid,
   output logic [stpe_pkg::PIPE_STAGES-1:0]   take
);
   import stpe_pkg::*;

   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES-1:0] vld_in;

   // A stage may load when the result side is not stalled or any stage at or after it holds a bubble
   for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_take
      assign take[i] = !rsp_stall || !(&vld_ff[PIPE_STAGES-1:i]);
   end

   // Advance valid bits with their data
   always_comb begin
      vld_in[0] = take[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         vld_in[i] = take[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !take[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&vld_ff) && rsp_stall))
      else $error("input stalled while the pipeline has a bubble");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transfer did not enter the first stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[PIPE_STAGES-1] && !rsp_stall && !vld_ff[PIPE_STAGES-2]) |=> !rsp_valid)
      else $error("result repeated after its transfer");

endmodule

// ===== design/stpe_range.sv =====
// ----------------------------------------------------------------------------
// stpe_range: range reduction
// Splits the absolute angle into a coarse step index and a residual angle,
// then picks the table point, the sin/cos choice and the result sign.
// ----------------------------------------------------------------------------
module stpe_range (
   input  logic                               clock,
   input  logic [stpe_pkg::RANGE_STAGES-1:0]  take,
   input  logic signed [31:0]                 angle,
   output logic signed [63:0]                 resid,
   output stpe_pkg::side_type                 side
);
   import stpe_pkg::*;

   logic [31:0]            ax0_ff, ax0_in;
   logic [31:0]            ax1_ff, ax2_ff;
   logic [4:0]             neg_ff;
   logic [N_W-1:0]         q1_ff, q1_in;
   logic [N_W-1:0]         q2_ff, q3_ff;
   logic [63:0]            qs2_ff, qs2_in;
   logic [63:0]            rem3_ff, rem3_in;
   logic [63:0]            rem4_ff, rem4_in;
   logic [N_W-1:0]         n4_ff, n4_in;
   logic signed [63:0]     d5_ff, d5_in;
   side_type               side5_ff, side5_in;
   logic [32+RECIP_W-1:0]  qprod;
   logic [63:0]            f60;
   logic                   ge;
   logic                   s4;
   logic                   s2;
   logic                   s1;

   // Magnitude, quotient estimate, back product, remainder, correction, fold
   always_comb begin
      ax0_in  = angle[31] ? (32'd0 - angle) : angle;
      qprod   = {{RECIP_W{1'b0}}, ax0_ff} * {32'd0, RECIP};
      q1_in   = qprod[32 +: N_W];
      qs2_in  = {{(64-N_W){1'b0}}, q1_ff} * STEP56;
      rem3_in = {ax2_ff, 32'd0} - qs2_ff;
      ge      = rem3_ff >= STEP56;
      n4_in   = ge ? (q3_ff + 1'b1) : q3_ff;
      rem4_in = ge ? (rem3_ff - STEP56) : rem3_ff;
      f60     = rem4_ff << 4;
      s4      = n4_ff[TABLE_BITS];
      s2      = n4_ff[TABLE_BITS+1];
      s1      = n4_ff[TABLE_BITS+2];
      d5_in   = s4 ? (STEP60 - f60) : f60;
      side5_in.idx      = s4 ? ~n4_ff[TABLE_BITS-1:0] : n4_ff[TABLE_BITS-1:0];
      side5_in.is_cos   = s2 ^ s4;
      side5_in.negative = neg_ff[4] ^ s1;
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         ax0_ff    <= ax0_in;
         neg_ff[0] <= angle[31];
      end
      if (take[1]) begin
         q1_ff     <= q1_in;
         ax1_ff    <= ax0_ff;
         neg_ff[1] <= neg_ff[0];
      end
      if (take[2]) begin
         qs2_ff    <= qs2_in;
         q2_ff     <= q1_ff;
         ax2_ff    <= ax1_ff;
         neg_ff[2] <= neg_ff[1];
      end
      if (take[3]) begin
         rem3_ff   <= rem3_in;
         q3_ff     <= q2_ff;
         neg_ff[3] <= neg_ff[2];
      end
      if (take[4]) begin
         rem4_ff   <= rem4_in;
         n4_ff     <= n4_in;
         neg_ff[4] <= neg_ff[3];
      end
      if (take[5]) begin
         d5_ff     <= d5_in;
         side5_ff  <= side5_in;
      end
   end

   assign resid = d5_ff;
   assign side  = side5_ff;

endmodule

// ===== design/stpe_mul60.sv =====
// ----------------------------------------------------------------------------
// stpe_mul60: pipelined Q.60 multiply-add
// result = addend + round(a * b), signed magnitude with half-up rounding,
// built from four 32x32 partial products over three stages.
// ----------------------------------------------------------------------------
module stpe_mul60 (
   input  logic                              clock,
   input  logic [stpe_pkg::MUL_STAGES-1:0]   take,
   input  logic signed [63:0]                a,
   input  logic signed [63:0]                b,
   input  logic signed [63:0]                addend,
   output logic signed [63:0]                result
);
   import stpe_pkg::*;

   logic [63:0]        ua_ff, ua_in;
   logic [63:0]        ub_ff, ub_in;
   logic               neg1_ff, neg2_ff;
   logic signed [63:0] add1_ff, add2_ff;
   logic [63:0]        ll_ff, ll_in;
   logic [63:0]        lh_ff, lh_in;
   logic [63:0]        hl_ff, hl_in;
   logic [63:0]        hh_ff, hh_in;
   logic [127:0]       sum;
   logic [63:0]        mag;
   logic signed [63:0] res_ff, res_in;

   // Magnitudes, partial products, sum with rounding and signed add
   always_comb begin
      ua_in  = a[63] ? (64'd0 - a) : a;
      ub_in  = b[63] ? (64'd0 - b) : b;
      ll_in  = 64'(ua_ff[31:0])  * 64'(ub_ff[31:0]);
      lh_in  = 64'(ua_ff[31:0])  * 64'(ub_ff[63:32]);
      hl_in  = 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
      hh_in  = 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
      sum    = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
             + {hh_ff, 64'd0} + {64'd0, ROUND_Q60};
      mag    = {1'b0, sum[122:60]};
      res_in = neg2_ff ? (add2_ff - signed'(mag)) : (add2_ff + signed'(mag));
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg1_ff <= a[63] ^ b[63];
         add1_ff <= addend;
      end
      if (take[1]) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         neg2_ff <= neg1_ff;
         add2_ff <= add1_ff;
      end
      if (take[2]) begin
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== design/stpe_horner.sv =====
// ----------------------------------------------------------------------------
// stpe_horner: sin and cos polynomials of the residual angle
// Two Horner lanes of multiply-add steps share one delay line of the
// residual angle.
// ----------------------------------------------------------------------------
module stpe_horner (
   input  logic                                clock,
   input  logic [stpe_pkg::HORNER_STAGES-1:0]  take,
   input  logic signed [63:0]                  resid,
   output logic signed [63:0]                  sin_poly,
   output logic signed [63:0]                  cos_poly
);
   import stpe_pkg::*;

   localparam int STEPS = POLY_TERMS - 1;
   localparam int D_LEN = HORNER_STAGES - MUL_STAGES;

   logic signed [63:0] d_ff [D_LEN];
   logic signed [63:0] acc_s [STEPS+1];
   logic signed [63:0] acc_c [STEPS+1];

   // Delay the residual alongside the lanes
   always_ff @(posedge clock) begin
      if (take[0]) begin
         d_ff[0] <= resid;
      end
      for (int i = 1; i < D_LEN; i++) begin
         if (take[i]) begin
            d_ff[i] <= d_ff[i-1];
         end
      end
   end

   assign acc_s[0] = poly_coef(1'b0, POLY_TERMS - 1);
   assign acc_c[0] = poly_coef(1'b1, POLY_TERMS - 1);

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic signed [63:0] ADD_S = poly_coef(1'b0, POLY_TERMS - 2 - s);
      localparam logic signed [63:0] ADD_C = poly_coef(1'b1, POLY_TERMS - 2 - s);
      logic signed [63:0] d_tap;
      if (s == 0) begin : g_first
         assign d_tap = resid;
      end else begin : g_later
         assign d_tap = d_ff[MUL_STAGES*s-1];
      end

      stpe_mul60 u_sin (
         .clock  (clock),
         .take   (take[MUL_STAGES*s +: MUL_STAGES]),
         .a      (acc_s[s]),
         .b      (d_tap),
         .addend (ADD_S),
         .result (acc_s[s+1])
      );

      stpe_mul60 u_cos (
         .clock  (clock),
         .take   (take[MUL_STAGES*s +: MUL_STAGES]),
         .a      (acc_c[s]),
         .b      (d_tap),
         .addend (ADD_C),
         .result (acc_c[s+1])
      );
   end

   assign sin_poly = acc_s[STEPS];
   assign cos_poly = acc_c[STEPS];

endmodule

// ===== design/sine_table_poly_eval_top.sv =====
// ----------------------------------------------------------------------------
// sine_table_poly_eval_top: sine of a Q8.24 angle, result in Q2.30
// Range reduction, table lookup, Horner polynomials and angle-addition
// combine in one stall-tolerant pipeline.
// ----------------------------------------------------------------------------
// Takes one angle per clock unless req_stall is raised and returns one sine
// per angle, in order. The depth comes from six range-reduction stages, five
// Horner multiply-add steps of three stages each, one more three-stage
// multiply for the table combine, and four stages of add, magnitude, rounding
// and sign; each multiply-add forms a 64x64 product from 32x32 partial
// products over three stages. When the output stalls, bubbles in the pipeline
// still close up, so input keeps being taken until every stage holds an item.
module sine_table_poly_eval_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sine
);
   import stpe_pkg::*;

   localparam logic [63:0] ROUND_Q30 = 64'h0000_0000_2000_0000;
   localparam logic [33:0] SAT_Q30   = 34'h0_4000_0000;

   logic [PIPE_STAGES-1:0] take;
   logic signed [63:0]     resid;
   side_type               side_r;
   side_type               sb_ff [SB_LEN];
   side_type               sb_tab;
   side_type               sb_last;
   logic signed [63:0]     sin_poly;
   logic signed [63:0]     cos_poly;
   logic signed [63:0]     tab_a;
   logic signed [63:0]     tab_b;
   logic signed [63:0]     m1;
   logic signed [63:0]     m2;
   logic signed [63:0]     y_ff, y_in;
   logic                   nega_ff, negb_ff, negc_ff;
   logic [63:0]            mag_ff, mag_in;
   logic [63:0]            rsum;
   logic [33:0]            rnd;
   logic [30:0]            rr_ff, rr_in;
   logic [31:0]            out_ff, out_in;

   stpe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .take      (take)
   );

   stpe_range u_range (
      .clock (clock),
      .take  (take[0 +: RANGE_STAGES]),
      .angle (req_angle),
      .resid (resid),
      .side  (side_r)
   );

   stpe_horner u_horner (
      .clock    (clock),
      .take     (take[HORNER_BASE +: HORNER_STAGES]),
      .resid    (resid),
      .sin_poly (sin_poly),
      .cos_poly (cos_poly)
   );

   // Carry table index and sign control past the polynomial stages
   always_ff @(posedge clock) begin
      if (take[HORNER_BASE]) begin
         sb_ff[0] <= side_r;
      end
      for (int i = 1; i < SB_LEN; i++) begin
         if (take[HORNER_BASE+i]) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   assign sb_tab  = sb_ff[HORNER_STAGES-1];
   assign sb_last = sb_ff[SB_LEN-1];

   // Pick table values for the angle-addition terms
   always_comb begin
      tab_a = sb_tab.is_cos ? signed'(COS_TAB[sb_tab.idx]) : signed'(SIN_TAB[sb_tab.idx]);
      tab_b = sb_tab.is_cos ? signed'(SIN_TAB[sb_tab.idx]) : signed'(COS_TAB[sb_tab.idx]);
   end

   stpe_mul60 u_mul_a (
      .clock  (clock),
      .take   (take[FINAL_BASE +: MUL_STAGES]),
      .a      (tab_a),
      .b      (cos_poly),
      .addend (64'sd0),
      .result (m1)
   );

   stpe_mul60 u_mul_b (
      .clock  (clock),
      .take   (take[FINAL_BASE +: MUL_STAGES]),
      .a      (tab_b),
      .b      (sin_poly),
      .addend (64'sd0),
      .result (m2)
   );

   // Combine, take magnitude, round to Q.30 with saturation, apply sign
   always_comb begin
      y_in   = sb_last.is_cos ? (m1 - m2) : (m1 + m2);
      mag_in = y_ff[63] ? (64'd0 - y_ff) : y_ff;
      rsum   = mag_ff + ROUND_Q30;
      rnd    = rsum[63:30];
      rr_in  = (rnd > SAT_Q30) ? SAT_Q30[30:0] : rnd[30:0];
      out_in = negc_ff ? (32'd0 - {1'b0, rr_ff}) : {1'b0, rr_ff};
   end

   always_ff @(posedge clock) begin
      if (take[ADD_STAGE]) begin
         y_ff    <= y_in;
         nega_ff <= sb_last.negative;
      end
      if (take[ABS_STAGE]) begin
         mag_ff  <= mag_in;
         negb_ff <= nega_ff ^ y_ff[63];
      end
      if (take[ROUND_STAGE]) begin
         rr_ff   <= rr_in;
         negc_ff <= negb_ff;
      end
      if (take[OUT_STAGE]) begin
         out_ff  <= out_in;
      end
   end

   assign rsp_sine = out_ff;

endmodule

// ===== tb/sine_table_poly_eval_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_table_poly_eval_checker: sine prediction and result comparison
// Watches both channels. Each accepted angle is turned into the expected
// Q2.30 sine by a bit-exact fixed-point model, and each accepted result is
// compared in order with the oldest expected sine.
// ----------------------------------------------------------------------------
module sine_table_poly_eval_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_angle,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_sine,
   output int                 fail_count,
   output int                 sines_pending,
   output int                 sines_checked
);
   import stpe_pkg::*;

   localparam logic [63:0] PI_FIX  = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] ONE_FIX = 64'h1000_0000_0000_0000;
   localparam logic [63:0] STEP_Q60 = PI_FIX >> (2 + TABLE_BITS);
   localparam logic [63:0] STEP_Q56 = PI_FIX >> (6 + TABLE_BITS);

   logic signed [63:0] sin_rom [TABLE_SIZE];
   logic signed [63:0] cos_rom [TABLE_SIZE];
   logic signed [63:0] sin_taylor [POLY_TERMS];
   logic signed [63:0] cos_taylor [POLY_TERMS];
   logic signed [31:0] sine_queue [$];

   // Q.60 product, magnitude rounded half up, sign applied last
   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      logic [63:0]  r;
      ua = a[63] ? 64'd0 - a : a;
      ub = b[63] ? 64'd0 - b : b;
      p  = {64'd0, ua} * {64'd0, ub} + (128'd1 << 59);
      r  = {1'b0, p[122:60]};
      return (a[63] != b[63]) ? 64'd0 - r : r;
   endfunction

   function automatic logic signed [63:0] eval_poly(input logic cos_lane,
                                                    input logic signed [63:0] d);
      logic signed [63:0] acc;
      acc = cos_lane ? cos_taylor[POLY_TERMS-1] : sin_taylor[POLY_TERMS-1];
      for (int k = POLY_TERMS - 2; k >= 0; k--) begin
         acc = (cos_lane ? cos_taylor[k] : sin_taylor[k]) + qmul(acc, d);
      end
      return acc;
   endfunction

   function automatic logic signed [31:0] predict_sine(input logic signed [31:0] angle);
      logic [63:0]        ax;
      logic [63:0]        ax56;
      logic [63:0]        n;
      logic [63:0]        f60;
      logic [63:0]        mag;
      logic [63:0]        r;
      logic [TABLE_BITS-1:0] t;
      logic signed [63:0] d;
      logic signed [63:0] ps;
      logic signed [63:0] pc;
      logic signed [63:0] y;
      logic               s4;
      logic               negative;
      ax   = angle[31] ? 64'h1_0000_0000 - {32'd0, angle} : {32'd0, angle};
      ax56 = ax << 32;
      n    = ax56 / STEP_Q56;
      f60  = (ax56 - n * STEP_Q56) << 4;
      s4   = n[TABLE_BITS];
      t    = s4 ? ~n[TABLE_BITS-1:0] : n[TABLE_BITS-1:0];
      d    = s4 ? STEP_Q60 - f60 : f60;
      negative = angle[31] ^ n[TABLE_BITS+2];
      ps   = eval_poly(1'b0, d);
      pc   = eval_poly(1'b1, d);
      if (n[TABLE_BITS+1] ^ s4) begin
         y = qmul(cos_rom[t], pc) - qmul(sin_rom[t], ps);
      end else begin
         y = qmul(sin_rom[t], pc) + qmul(cos_rom[t], ps);
      end
      if (y[63]) begin
         negative = !negative;
         mag = 64'd0 - y;
      end else begin
         mag = y;
      end
      r = (mag + (64'd1 << 29)) >> 30;
      if (r > (64'd1 << 30)) r = 64'd1 << 30;
      return negative ? 32'd0 - r[31:0] : r[31:0];
   endfunction

   // Build the table and Taylor coefficients once
   initial begin
      logic signed [63:0] fact;
      logic signed [63:0] c;
      logic signed [63:0] a;
      logic signed [63:0] a2;
      logic signed [63:0] st;
      logic signed [63:0] ct;
      logic signed [63:0] s;
      logic signed [63:0] cc;
      fact = 1;
      for (int k = 0; k < POLY_TERMS; k++) begin
         if (k > 1) fact = fact * k;
         c = $signed(ONE_FIX) / fact;
         if (((k / 2) & 1) == 1) c = -c;
         sin_taylor[k] = (k & 1) ? c : 64'sd0;
         cos_taylor[k] = (k & 1) ? 64'sd0 : c;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         a  = STEP_Q60 * i;
         a2 = qmul(a, a);
         st = a;
         ct = ONE_FIX;
         s  = a;
         cc = ONE_FIX;
         for (int k = 1; k <= 14; k++) begin
            st = qmul(st, a2) / 64'((2 * k) * (2 * k + 1));
            ct = qmul(ct, a2) / 64'((2 * k - 1) * (2 * k));
            if (k & 1) begin
               s  = s - st;
               cc = cc - ct;
            end else begin
               s  = s + st;
               cc = cc + ct;
            end
         end
         sin_rom[i] = s;
         cos_rom[i] = cc;
      end
   end

   // Predict on each angle transfer, compare on each sine transfer
   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         sine_queue.delete();
         fail_count    <= 0;
         sines_checked <= 0;
      end else begin
         if (req_valid && !req_stall) sine_queue.push_back(predict_sine(req_angle));
         if (rsp_valid && !rsp_stall) begin
            sines_checked <= sines_checked + 1;
            if (sine_queue.size() == 0) begin
               $error("sine: unexpected result %0d with nothing outstanding", rsp_sine);
               fail_count <= fail_count + 1;
            end else begin
               want = sine_queue.pop_front();
               if (want !== rsp_sine) begin
                  $error("sine: expected %0d, got %0d", want, rsp_sine);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      sines_pending <= sine_queue.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sine table / polynomial evaluator
// Sends directed angles (range extremes, octant edges, multiples of pi/2)
// then random angles mixed between full range, small angles and points near
// step edges, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ANGLES = 1200;
   localparam int STEP_Q824     = 1647099;   // pi/32 in Q8.24, truncated

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_angle;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_sine;
   logic               idle_on;
   int                 stall_left;
   int                 fail_count;
   int                 sines_pending;
   int                 sines_checked;
   int                 angles_sent;

   sine_table_poly_eval_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_sine  (rsp_sine)
   );

   sine_table_poly_eval_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sine      (rsp_sine),
      .fail_count    (fail_count),
      .sines_pending (sines_pending),
      .sines_checked (sines_checked)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one angle, maybe after an idle burst, and hold it until taken
   task automatic send_angle(input logic signed [31:0] angle);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= angle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      angles_sent++;
   endtask

   initial begin
      logic signed [31:0] angle;
      logic signed [31:0] edges [] = '{32'sd0, 32'sd1, -32'sd1, 32'h7fff_ffff,
         32'h8000_0000, 32'h8000_0001, 32'sd26353589, -32'sd26353589,
         32'sd52707179, -32'sd52707179, 32'sd13176795, 32'sd1647099,
         32'sd1647100, 32'sd3294199, 32'sd105414357, 32'sd39530384,
         32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff, -32'sd13176795};
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_angle  = '0;
      idle_on    = 1'b1;
      angles_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (edges[i]) send_angle(edges[i]);

      // Random angles; idle only in alternating stretches, none at the end
      for (int i = 0; i < RANDOM_ANGLES; i++) begin
         idle_on <= (i < RANDOM_ANGLES - 200) && ((i / 150) % 2 == 0);
         case ($urandom_range(0, 3))
            0: angle = $urandom;
            1: angle = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            2: angle = (($urandom_range(0, 1000) * STEP_Q824) + $urandom_range(0, 6) - 3)
                       * ($urandom_range(0, 1) ? 1 : -1);
            default: angle = $signed($urandom_range(0, 4095)) - 2048;
         endcase
         send_angle(angle);
      end
      req_valid <= 1'b0;

      while (sines_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d angles and checked %0d sines: extremes, octant edges,",
               angles_sent, sines_checked);
      $display("small and full-range random angles under input and output stalls.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
